// ----- rtl/leveled_merge_trigger_policy_macros.svh -----
// Assertion macros for the leveled merge trigger policy
`ifndef LEVELED_MERGE_TRIGGER_POLICY_MACROS_SVH
`define LEVELED_MERGE_TRIGGER_POLICY_MACROS_SVH

// same-cycle implication
`define LMTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmtp assertion failed");

// next-cycle implication
`define LMTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmtp assertion failed");

`endif

// ----- rtl/lmtp_pkg.sv -----
// Shared types, constants and helpers of the leveled merge trigger policy
package lmtp_pkg;

    localparam int LEVEL_COUNT_DEF     = 32;
    localparam int SLOTS_PER_LEVEL_DEF = 32;
    localparam int CASCADE_LIMIT_DEF   = 3;

    localparam int SIZE_W  = 48;
    localparam int FILL_W  = 6;
    localparam int LEVEL_W = 5;
    localparam int ID_W    = 16;
    localparam int DOCS_W  = 32;
    localparam int CFG_W   = 16;

    localparam logic [SIZE_W-1:0] SAT48   = {SIZE_W{1'b1}};
    localparam logic [SIZE_W:0]   POW_SAT = {1'b1, {SIZE_W{1'b0}}};

    localparam logic [4:0]  MERGE_FACTOR_RST    = 5'd3;
    localparam logic [15:0] SIZE_DIVISOR_RST    = 16'd1;
    localparam logic [4:0]  COLLISION_COUNT_RST = 5'd3;

    localparam logic [1:0] CFG_MERGE_FACTOR    = 2'd0;
    localparam logic [1:0] CFG_SIZE_DIVISOR    = 2'd1;
    localparam logic [1:0] CFG_COLLISION_COUNT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LVL,
        S_RD,
        S_MLVL,
        S_MCHK,
        S_COPY,
        S_ESTART,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [SIZE_W-1:0] total;
    } meta_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] lvl;
    } lvl_stat_t;

    function automatic logic [SIZE_W-1:0] add_sat(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? SAT48 : s[SIZE_W-1:0];
    endfunction

endpackage

// ----- rtl/leveled_merge_trigger_policy.sv -----
// Top level of the leveled merge trigger policy
//
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// input     | start / busy         | segment_id, doc_count
// result    | result_valid strobe  | merge_now, level, member_id, merged_size, last
// config    | cfg_write            | cfg_index, cfg_data
//
// Per item: a divide (skipped when size_divisor is zero), a level search and one
// metadata read; each cascade move adds a level search, a check and a copy of the
// source members; a merge run takes one memory read, then one result per cycle.
// Reset clears level-present bits at once; results cannot stall, and busy is
// already low when the last one is shown.
module leveled_merge_trigger_policy
    import lmtp_pkg::*;
#(
    parameter int LEVEL_COUNT     = LEVEL_COUNT_DEF,
    parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF,
    parameter int CASCADE_LIMIT   = CASCADE_LIMIT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ID_W-1:0]     segment_id,
    input  logic [DOCS_W-1:0]   doc_count,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                result_valid,
    output logic                merge_now,
    output logic [LEVEL_W-1:0]  level,
    output logic [ID_W-1:0]     member_id,
    output logic [SIZE_W-1:0]   merged_size,
    output logic                last
);

`include "leveled_merge_trigger_policy_macros.svh"

    localparam int TOP_LEVEL = (LEVEL_COUNT - 1 < 31) ? (LEVEL_COUNT - 1) : 31;
    localparam int CAP       = (SLOTS_PER_LEVEL < 32) ? SLOTS_PER_LEVEL : 32;
    localparam int LVL_IDX_W = $clog2(LEVEL_COUNT);
    localparam int MEM_DEPTH = LEVEL_COUNT * SLOTS_PER_LEVEL;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MOVE_W    = $clog2(CASCADE_LIMIT + 2);

    logic [4:0]  merge_factor_reg;
    logic [15:0] size_divisor_reg;
    logic [4:0]  collision_count_reg;

    state_t state_reg, state_next;

    logic [ID_W-1:0]    id_reg, id_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [LEVEL_W-1:0] src_reg, src_next;
    logic [FILL_W-1:0]  src_fill_reg, src_fill_next;
    logic [SIZE_W-1:0]  src_total_reg, src_total_next;
    logic [FILL_W-1:0]  dst_fill_reg, dst_fill_next;
    logic [SIZE_W-1:0]  dst_total_reg, dst_total_next;
    logic [MOVE_W-1:0]  moves_reg, moves_next;
    logic [FILL_W-1:0]  j_reg, j_next;
    logic               pend_reg, pend_next;
    logic [LEVEL_COUNT-1:0] present_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_merge_reg, out_merge_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [SIZE_W-1:0]  out_size_reg, out_size_next;
    logic               out_last_reg, out_last_next;

    meta_t meta_mem [LEVEL_COUNT];
    meta_t meta_q;
    logic                 meta_we, meta_re;
    logic [LVL_IDX_W-1:0] meta_waddr, meta_raddr;
    meta_t                meta_wdata;

    logic [ID_W-1:0]   mem [MEM_DEPTH];
    logic [ID_W-1:0]   mem_q;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ID_W-1:0]   mem_wdata;

    logic               present_set;
    logic               div_start, div_done;
    logic [33:0]        div_q;
    logic               lvl_start;
    logic [SIZE_W-1:0]  lvl_size;
    lvl_stat_t          lvl_stat;

    logic [LEVEL_W:0]     dst_lvl;
    logic [LVL_IDX_W-1:0] src_idx, dst_idx;
    meta_t                rec;
    logic [SIZE_W-1:0]    tot;
    logic [FILL_W-1:0]    nf;
    logic                 em_last;

    function automatic logic [ADDR_W-1:0] slot_addr(logic [LEVEL_W-1:0] l, logic [FILL_W-1:0] k);
        return ADDR_W'(32'(l) * SLOTS_PER_LEVEL + 32'(k));
    endfunction

    lmtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, doc_count, 1'b0} + 34'(size_divisor_reg)),
        .divisor  ({1'b0, size_divisor_reg} << 1),
        .done     (div_done),
        .quotient (div_q)
    );

    lmtp_lvl #(
        .TOP_LEVEL (TOP_LEVEL)
    ) u_lvl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lvl_start),
        .size   (lvl_size),
        .factor (merge_factor_reg),
        .stat   (lvl_stat)
    );

    assign dst_lvl = {1'b0, src_reg} + 6'd1;
    assign src_idx = src_reg[LVL_IDX_W-1:0];
    assign dst_idx = dst_lvl[LVL_IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        lvl_next       = lvl_reg;
        src_next       = src_reg;
        src_fill_next  = src_fill_reg;
        src_total_next = src_total_reg;
        dst_fill_next  = dst_fill_reg;
        dst_total_next = dst_total_reg;
        moves_next     = moves_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        out_valid_next = 1'b0;
        out_merge_next = out_merge_reg;
        out_level_next = out_level_reg;
        out_id_next    = out_id_reg;
        out_size_next  = out_size_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        lvl_start      = 1'b0;
        lvl_size       = size_reg;
        meta_we        = 1'b0;
        meta_waddr     = src_idx;
        meta_wdata     = '0;
        meta_re        = 1'b0;
        meta_raddr     = src_idx;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr(src_reg, '0);
        mem_wdata      = mem_q;
        mem_re         = 1'b0;
        mem_raddr      = slot_addr(src_reg, j_reg);
        present_set    = 1'b0;
        rec            = meta_q;
        tot            = '0;
        nf             = '0;
        em_last        = (7'(j_reg) + 7'd1) == 7'(src_fill_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next = segment_id;
                    if (size_divisor_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        lvl_start  = 1'b1;
                        state_next = S_LVL;
                    end
                end
            end
            S_DIV:
            begin
                lvl_size = 48'(div_q);
                if (div_done)
                begin
                    size_next  = 48'(div_q);
                    lvl_start  = 1'b1;
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                if (lvl_stat.done)
                begin
                    lvl_next   = lvl_stat.lvl;
                    src_next   = lvl_stat.lvl;
                    meta_re    = 1'b1;
                    meta_raddr = lvl_stat.lvl[LVL_IDX_W-1:0];
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (!present_reg[src_idx])
                begin
                    rec = '0;
                end
                tot = add_sat(rec.total, size_reg);
                nf  = rec.fill;
                if (32'(rec.fill) < CAP)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(src_reg, rec.fill);
                    mem_wdata = id_reg;
                    nf        = rec.fill + 6'd1;
                end
                meta_we          = 1'b1;
                meta_wdata.fill  = nf;
                meta_wdata.total = tot;
                present_set      = 1'b1;
                src_fill_next    = nf;
                src_total_next   = tot;
                moves_next       = '0;
                if (present_reg[src_idx] && (nf >= 6'(collision_count_reg)))
                begin
                    lvl_start  = 1'b1;
                    lvl_size   = tot;
                    state_next = S_MLVL;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_merge_next = 1'b0;
                    out_level_next = lvl_reg;
                    out_id_next    = id_reg;
                    out_size_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MLVL:
            begin
                lvl_size = src_total_reg;
                if (lvl_stat.done)
                begin
                    if ((dst_lvl <= {1'b0, lvl_stat.lvl}) && (32'(dst_lvl) < LEVEL_COUNT)
                        && (32'(moves_reg) <= CASCADE_LIMIT))
                    begin
                        meta_re    = 1'b1;
                        meta_raddr = dst_idx;
                        state_next = S_MCHK;
                    end
                    else
                    begin
                        state_next = S_ESTART;
                    end
                end
            end
            S_MCHK:
            begin
                if (!present_reg[dst_idx] ||
                    ((7'(meta_q.fill) + 7'd1) < 7'(collision_count_reg)))
                begin
                    state_next = S_ESTART;
                end
                else
                begin
                    dst_fill_next  = meta_q.fill;
                    dst_total_next = add_sat(meta_q.total, src_total_reg);
                    meta_we        = 1'b1;
                    j_next         = '0;
                    pend_next      = 1'b0;
                    state_next     = S_COPY;
                end
            end
            S_COPY:
            begin
                pend_next = 1'b0;
                if (j_reg < src_fill_reg)
                begin
                    mem_re    = 1'b1;
                    j_next    = j_reg + 6'd1;
                    pend_next = 1'b1;
                end
                if (pend_reg && (32'(dst_fill_reg) < CAP))
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = slot_addr(dst_lvl[LEVEL_W-1:0], dst_fill_reg);
                    dst_fill_next = dst_fill_reg + 6'd1;
                end
                if (!(j_reg < src_fill_reg) && !pend_reg)
                begin
                    meta_we          = 1'b1;
                    meta_waddr       = dst_idx;
                    meta_wdata.fill  = dst_fill_reg;
                    meta_wdata.total = dst_total_reg;
                    src_next         = dst_lvl[LEVEL_W-1:0];
                    src_fill_next    = dst_fill_reg;
                    src_total_next   = dst_total_reg;
                    moves_next       = moves_reg + MOVE_W'(1);
                    lvl_start        = 1'b1;
                    lvl_size         = dst_total_reg;
                    state_next       = S_MLVL;
                end
            end
            S_ESTART:
            begin
                if (src_fill_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_merge_next = 1'b0;
                    out_level_next = lvl_reg;
                    out_id_next    = id_reg;
                    out_size_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_addr(src_reg, '0);
                    j_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_merge_next = 1'b1;
                out_level_next = src_reg;
                out_id_next    = mem_q;
                out_size_next  = src_total_reg;
                out_last_next  = em_last;
                if (em_last)
                begin
                    meta_we    = 1'b1;
                    size_next  = 48'd1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_addr(src_reg, j_reg + 6'd1);
                    j_next    = j_reg + 6'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            present_reg         <= '0;
            size_reg            <= 48'd1;
            out_valid_reg       <= 1'b0;
            merge_factor_reg    <= MERGE_FACTOR_RST;
            size_divisor_reg    <= SIZE_DIVISOR_RST;
            collision_count_reg <= COLLISION_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            if (present_set)
            begin
                present_reg[src_idx] <= 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MERGE_FACTOR:    merge_factor_reg    <= cfg_data[4:0];
                    CFG_SIZE_DIVISOR:    size_divisor_reg    <= cfg_data;
                    CFG_COLLISION_COUNT: collision_count_reg <= cfg_data[4:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        lvl_reg       <= lvl_next;
        src_reg       <= src_next;
        src_fill_reg  <= src_fill_next;
        src_total_reg <= src_total_next;
        dst_fill_reg  <= dst_fill_next;
        dst_total_reg <= dst_total_next;
        moves_reg     <= moves_next;
        j_reg         <= j_next;
        pend_reg      <= pend_next;
        out_merge_reg <= out_merge_next;
        out_level_reg <= out_level_next;
        out_id_reg    <= out_id_next;
        out_size_reg  <= out_size_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (meta_re)
        begin
            meta_q <= meta_mem[meta_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = out_valid_reg;
    assign merge_now    = out_merge_reg;
    assign level        = out_level_reg;
    assign member_id    = out_id_reg;
    assign merged_size  = out_size_reg;
    assign last         = out_last_reg;

    `LMTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LMTP_ASSERT_NOW(a_ack_is_last, result_valid && !merge_now, last)
    `LMTP_ASSERT_NEXT(a_run_continues, result_valid && !last, result_valid && merge_now)
    `LMTP_ASSERT_NOW(a_last_frees, result_valid && last, !busy)

endmodule

// ----- rtl/lmtp_div.sv -----
// Restoring divider, one quotient bit per cycle
module lmtp_div
    import lmtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [33:0] quotient
);

    logic [33:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[33]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = 17'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[16:0];
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/lmtp_lvl.sv -----
// Level search: floor(log_m(size)) with saturating powers, one power per cycle
module lmtp_lvl
    import lmtp_pkg::*;
#(
    parameter int TOP_LEVEL = 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] size,
    input  logic [4:0]        factor,
    output lvl_stat_t         stat
);

    logic               busy_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W:0]    p_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [53:0]        prod;
    logic [SIZE_W:0]    pn;
    logic               fin;

    always_comb
    begin
        prod = {5'b0, p_reg} * {49'b0, factor};
        pn   = (prod > 54'(POW_SAT)) ? POW_SAT : prod[SIZE_W:0];
        fin  = (size_reg == '0) || (32'(lvl_reg) == TOP_LEVEL) || ({1'b0, size_reg} < pn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && fin)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            size_reg <= size;
            p_reg    <= 49'd1;
            lvl_reg  <= '0;
        end
        else if (busy_reg && !fin)
        begin
            p_reg   <= pn;
            lvl_reg <= lvl_reg + 5'd1;
        end
    end

    assign stat.done = busy_reg && fin;
    assign stat.lvl  = lvl_reg;

endmodule

// ----- tb/tb_leveled_merge_trigger_policy.sv -----
// Self-checking testbench of the leveled merge trigger policy: directed table, then random phases
module tb_leveled_merge_trigger_policy
    import lmtp_pkg::*;
();

    localparam logic [1:0]  CFG_SPARE = 2'd3;
    localparam logic [63:0] POW_CAP   = 64'h1_0000_0000_0000;
    localparam int          NUM_LEVELS = 32;
    localparam int          SLOT_CAP   = 32;
    localparam int          MAX_MOVES  = 3;

    typedef struct packed {
        logic              merge;
        logic [4:0]        lvl;
        logic [15:0]       id;
        logic [47:0]       size;
        logic              fin;
    } merge_result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

    typedef struct {
        row_kind_e     kind;
        logic [1:0]    idx;
        logic [15:0]   val;
        logic [15:0]   id;
        logic [31:0]   docs;
        bit            typed;
        merge_result_t res;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [15:0]        segment_id = '0;
    logic [31:0]        doc_count = '0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               busy;
    logic               result_valid;
    logic               merge_now;
    logic [4:0]         level;
    logic [15:0]        member_id;
    logic [47:0]        merged_size;
    logic               last;

    // predictor state
    logic [4:0]         mf;
    logic [15:0]        divisor;
    logic [4:0]         trig_count;
    bit                 lvl_present [NUM_LEVELS];
    int unsigned        lvl_fill [NUM_LEVELS];
    logic [47:0]        lvl_total [NUM_LEVELS];
    logic [15:0]        lvl_members [NUM_LEVELS][SLOT_CAP];
    logic [47:0]        cur_size;

    merge_result_t      pending_results [$];
    merge_result_t      oldest;
    bit                 mismatch_seen = 0;
    dir_row_t           dir_rows [22];

    leveled_merge_trigger_policy uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .segment_id(segment_id), .doc_count(doc_count),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .merge_now(merge_now), .level(level),
        .member_id(member_id), .merged_size(merged_size), .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(8 * 2000000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic int unsigned size_level(logic [47:0] sz);
        int unsigned l;
        logic [63:0] p;
        l = 0;
        p = 64'd1;
        if (sz == 0)
            return 0;
        while (l < 31)
        begin
            if (mf != 0 && p > POW_CAP / {59'd0, mf})
                p = POW_CAP;
            else
                p = p * {59'd0, mf};
            if (p > POW_CAP)
                p = POW_CAP;
            if ({16'd0, sz} >= p)
                l++;
            else
                break;
        end
        return l;
    endfunction

    function automatic void file_member(int unsigned l, logic [15:0] id);
        if (lvl_fill[l] < SLOT_CAP)
        begin
            lvl_members[l][lvl_fill[l]] = id;
            lvl_fill[l]++;
        end
    endfunction

    function automatic void push_result(logic m, int unsigned l, logic [15:0] id,
                                        logic [47:0] sz, logic f);
        merge_result_t r;
        r.merge = m;
        r.lvl   = l[4:0];
        r.id    = id;
        r.size  = sz;
        r.fin   = f;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_cascade(int unsigned l, logic [15:0] id);
        int unsigned src;
        int unsigned nl;
        int unsigned moves;
        int unsigned n;
        logic [47:0] tot;
        src = l;
        nl = size_level(lvl_total[l]);
        moves = 0;
        for (int unsigned i = l + 1; i <= nl && i < NUM_LEVELS && moves <= MAX_MOVES; i++)
        begin
            if (!lvl_present[i])
                break;
            if (lvl_fill[i] + 1 < trig_count)
                break;
            for (int unsigned j = 0; j < lvl_fill[src]; j++)
                file_member(i, lvl_members[src][j]);
            lvl_fill[src] = 0;
            lvl_total[i] = sat_sum(lvl_total[i], lvl_total[src]);
            lvl_total[src] = '0;
            nl = size_level(lvl_total[i]);
            src = i;
            moves++;
        end
        n = lvl_fill[src];
        if (n == 0)
        begin
            push_result(1'b0, l, id, '0, 1'b1);
            return;
        end
        tot = lvl_total[src];
        for (int unsigned j = 0; j < n; j++)
            push_result(1'b1, src, lvl_members[src][j], tot, j + 1 == n);
        lvl_total[src] = '0;
        lvl_fill[src] = 0;
        cur_size = 48'd1;
    endfunction

    function automatic void predict_add(logic [15:0] id, logic [31:0] docs);
        int unsigned l;
        logic [63:0] num;
        if (divisor != 0)
        begin
            num = 64'd2 * {32'd0, docs} + {48'd0, divisor};
            cur_size = 48'(num / (64'd2 * {48'd0, divisor}));
        end
        l = size_level(cur_size);
        if (!lvl_present[l])
        begin
            lvl_present[l] = 1;
            lvl_fill[l] = 0;
            lvl_total[l] = cur_size;
            file_member(l, id);
            push_result(1'b0, l, id, '0, 1'b1);
            return;
        end
        lvl_total[l] = sat_sum(lvl_total[l], cur_size);
        file_member(l, id);
        if (lvl_fill[l] >= trig_count)
            predict_cascade(l, id);
        else
            push_result(1'b0, l, id, '0, 1'b1);
    endfunction

    task automatic drain();
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        start <= 1'b0;
        @(posedge clk);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MERGE_FACTOR:    mf = val[4:0];
            CFG_SIZE_DIVISOR:    divisor = val;
            CFG_COLLISION_COUNT: trig_count = val[4:0];
            default: ;
        endcase
    endtask

    // leaves start high; caller lowers it for a gap
    task automatic send_item(input logic [15:0] id, input logic [31:0] docs,
                             input bit typed, input merge_result_t exp);
        int n0;
        start      <= 1'b1;
        segment_id <= id;
        doc_count  <= docs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n0 = pending_results.size();
        predict_add(id, docs);
        if (typed)
        begin
            while (pending_results.size() > n0)
                void'(pending_results.pop_back());
            pending_results.push_back(exp);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: member_id %0h", member_id);
                mismatch_seen = 1;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (merge_now !== oldest.merge)
                begin
                    $error("merge_now exp %0h got %0h", oldest.merge, merge_now);
                    mismatch_seen = 1;
                end
                if (level !== oldest.lvl)
                begin
                    $error("level exp %0d got %0d", oldest.lvl, level);
                    mismatch_seen = 1;
                end
                if (member_id !== oldest.id)
                begin
                    $error("member_id exp %0h got %0h", oldest.id, member_id);
                    mismatch_seen = 1;
                end
                if (merged_size !== oldest.size)
                begin
                    $error("merged_size exp %0h got %0h", oldest.size, merged_size);
                    mismatch_seen = 1;
                end
                if (last !== oldest.fin)
                begin
                    $error("last exp %0h got %0h", oldest.fin, last);
                    mismatch_seen = 1;
                end
            end
        end
    end

    initial
    begin
        logic [15:0] ph_mf [7];
        logic [15:0] ph_div [7];
        logic [15:0] ph_cc [7];
        merge_result_t none;
        int burst_left;
        logic [31:0] docs;

        none = '0;
        mf = MERGE_FACTOR_RST;
        divisor = SIZE_DIVISOR_RST;
        trig_count = COLLISION_COUNT_RST;
        cur_size = 48'd1;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            lvl_present[i] = 0;
            lvl_fill[i] = 0;
            lvl_total[i] = '0;
        end

        dir_rows = '{
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0001, 32'd0, 1, '{1'b0, 5'd0, 16'h0001, 48'd0, 1'b1}},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0002, 32'd1, 1, '{1'b0, 5'd0, 16'h0002, 48'd0, 1'b1}},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0003, 32'd2, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'hFFFF, 32'hFFFFFFFF, 1,
              '{1'b0, 5'd20, 16'hFFFF, 48'd0, 1'b1}},
            '{ROW_CFG,  CFG_SIZE_DIVISOR, 16'h0000, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0004, 32'd12345, 0, none},
            '{ROW_CFG,  CFG_SIZE_DIVISOR, 16'hFFFF, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0005, 32'hFFFFFFFF, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h8000, 32'd7, 0, none},
            '{ROW_CFG,  CFG_SIZE_DIVISOR, 16'h0001, 16'h0, 32'd0, 0, none},
            '{ROW_CFG,  CFG_MERGE_FACTOR, 16'h0000, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0006, 32'd7, 1, '{1'b0, 5'd31, 16'h0006, 48'd0, 1'b1}},
            '{ROW_CFG,  CFG_MERGE_FACTOR, 16'h0001, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0007, 32'd9, 0, none},
            '{ROW_CFG,  CFG_COLLISION_COUNT, 16'h0000, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0008, 32'd100, 0, none},
            '{ROW_CFG,  CFG_SPARE, 16'hFFFF, 16'h0, 32'd0, 0, none},
            '{ROW_CFG,  CFG_MERGE_FACTOR, 16'h0010, 16'h0, 32'd0, 0, none},
            '{ROW_CFG,  CFG_COLLISION_COUNT, 16'h0001, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h0009, 32'd0, 0, none},
            '{ROW_CFG,  CFG_MERGE_FACTOR, 16'hFFE2, 16'h0, 32'd0, 0, none},
            '{ROW_ITEM, CFG_SPARE, 16'h0, 16'h000A, 32'd3, 0, none}
        };

        // merge factor, divisor, collision count per random phase
        ph_mf  = '{16'd3, 16'd2, 16'd16, 16'd4, 16'd5, 16'd2, 16'd0};
        ph_div = '{16'd1, 16'd1, 16'd1,  16'd0, 16'd7, 16'd65535, 16'd0};
        ph_cc  = '{16'd3, 16'd2, 16'd16, 16'd2, 16'd1, 16'd4, 16'd0};
        ph_mf[6]  = 16'($urandom_range(2, 16));
        ph_div[6] = 16'($urandom_range(0, 8));
        ph_cc[6]  = 16'($urandom_range(1, 16));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_item(dir_rows[r].id, dir_rows[r].docs, dir_rows[r].typed, dir_rows[r].res);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(CFG_MERGE_FACTOR, ph_mf[ph]);
            write_reg(CFG_SIZE_DIVISOR, ph_div[ph]);
            write_reg(CFG_COLLISION_COUNT, ph_cc[ph]);
            burst_left = $urandom_range(1, 20);
            repeat (46)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: docs = $urandom_range(0, 40);
                    6, 7:             docs = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 3);
                    default:          docs = $urandom();
                endcase
                send_item(16'($urandom()), docs, 0, none);
                burst_left--;
                if (burst_left == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                    burst_left = $urandom_range(1, 20);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!mismatch_seen && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lmtp_pkg.sv
rtl/lmtp_div.sv
rtl/lmtp_lvl.sv
rtl/leveled_merge_trigger_policy.sv
tb/tb_leveled_merge_trigger_policy.sv
